// ----- rtl/isq_pkg.sv -----
// Package for the indexed sequence store: request and status codes and the
// fixed field widths of the request and response channels.
// No dependencies; every other file but isq_mem imports it.
`default_nettype none

package isq_pkg;

  // Fixed widths of the channel fields.
  localparam int ReqW = 3;
  localparam int PosW = 6;
  localparam int ValW = 32;

  // Request codes carried in req_type.
  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_HEAD = 3'd0,
    REQ_PUSH_TAIL = 3'd1,
    REQ_POP_HEAD  = 3'd2,
    REQ_POP_TAIL  = 3'd3,
    REQ_INSERT    = 3'd4,
    REQ_REMOVE    = 3'd5,
    REQ_FIND      = 3'd6
  } req_type_e;

  // Status codes returned with every response.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ----- rtl/isq_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on isq_pkg for the fixed field widths.
`default_nettype none

// Request channel: one request per accepted transfer.
interface isq_req_if;
  import isq_pkg::*;

  logic            valid;
  logic            ready;
  logic [ReqW-1:0] req_type;
  logic [ValW-1:0] value_in;
  logic [PosW-1:0] position;

  modport source (output valid, req_type, value_in, position, input ready);
  modport sink   (input valid, req_type, value_in, position, output ready);
endinterface

// Response channel: count fields are sized for the store depth.
interface isq_rsp_if #(
  parameter int CNT_W = 5
);
  import isq_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [CNT_W-1:0] found_position;
  logic [ValW-1:0]  front_value;
  logic [ValW-1:0]  back_value;
  logic [CNT_W-1:0] length;
  logic             is_empty;

  modport source (output valid, status, found_position, front_value, back_value, length,
                  is_empty, input ready);
  modport sink   (input valid, status, found_position, front_value, back_value, length,
                  is_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/indexed_sequence_store_core.sv -----
// Indexed sequence store: a bounded ordered list of up to LIST_DEPTH values
// with push and pop at both ends, insert and remove at a position, and find.
// Each request gives one response with status, find position, front and back
// values, length and an empty flag. After a request is accepted, the
// sequencer walks k entries, where k is the number of entries moved
// (insert, remove, pops and pushes) or searched (find, the whole length),
// up to LIST_DEPTH; the walk goes through the entry memory's single read
// port at one entry per cycle, and two more reads fetch front and back.
// A new request is taken as soon as the previous response is handed to
// the output register. The entry memory needs no clearing after reset.
// Depends on isq_pkg, isq_if, isq_mem and isq_ctrl.
`default_nettype none

module indexed_sequence_store_core import isq_pkg::*; #(
  parameter int LIST_DEPTH = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  isq_req_if.sink   req_i,
  isq_rsp_if.source rsp_o
);

  localparam int AddrW = $clog2(LIST_DEPTH);
  localparam int CntW  = $clog2(LIST_DEPTH + 1);

  logic                  res_valid;
  logic                  res_ready;
  status_e               res_status;
  logic [CntW-1:0]       res_found;
  logic [ValW-1:0]       res_front;
  logic [ValW-1:0]       res_back;
  logic [CntW-1:0]       res_length;

  logic                  mem_re;
  logic [AddrW-1:0]      mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;

  logic                  rsp_valid_q;
  status_e               rsp_status_q;
  logic [CntW-1:0]       rsp_found_q;
  logic [ValW-1:0]       rsp_front_q;
  logic [ValW-1:0]       rsp_back_q;
  logic [CntW-1:0]       rsp_length_q;

  isq_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .req_type_i  (req_i.req_type),
    .value_i     (req_i.value_in),
    .position_i  (req_i.position),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .status_o    (res_status),
    .found_o     (res_found),
    .front_o     (res_front),
    .back_o      (res_back),
    .length_o    (res_length),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  isq_mem #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (VALUE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // Output register: takes a new response whenever it is empty or draining.
  assign res_ready = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res_ready) begin
      rsp_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      rsp_status_q <= res_status;
      rsp_found_q  <= res_found;
      rsp_front_q  <= res_front;
      rsp_back_q   <= res_back;
      rsp_length_q <= res_length;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.found_position = rsp_found_q;
  assign rsp_o.front_value    = rsp_front_q;
  assign rsp_o.back_value     = rsp_back_q;
  assign rsp_o.length         = rsp_length_q;
  assign rsp_o.is_empty       = (rsp_length_q == '0);

endmodule

`default_nettype wire

// ----- rtl/isq_mem.sv -----
// Entry storage of the indexed sequence store: one write port and one read
// port with registered read data. Depends on isq_pkg only by convention.
`default_nettype none

module isq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; returns the contents before a write in the same cycle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/isq_ctrl.sv -----
// Sequencer of the indexed sequence store: decodes a request, walks the entry
// memory one entry per cycle to shift or search, then reads front and back.
// Depends on isq_pkg.
`default_nettype none

module isq_ctrl import isq_pkg::*; #(
  parameter int LIST_DEPTH = 16,
  parameter int VALUE_BITS = 32,
  localparam int AddrW = $clog2(LIST_DEPTH),
  localparam int CntW  = $clog2(LIST_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Request side.
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ReqW-1:0]       req_type_i,
  input  wire logic [ValW-1:0]       value_i,
  input  wire logic [PosW-1:0]       position_i,
  // Result side.
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output status_e                    status_o,
  output logic      [CntW-1:0]       found_o,
  output logic      [ValW-1:0]       front_o,
  output logic      [ValW-1:0]       back_o,
  output logic      [CntW-1:0]       length_o,
  // Entry memory.
  output logic                       mem_re_o,
  output logic      [AddrW-1:0]      mem_raddr_o,
  input  wire logic [VALUE_BITS-1:0] mem_rdata_i,
  output logic                       mem_we_o,
  output logic      [AddrW-1:0]      mem_waddr_o,
  output logic      [VALUE_BITS-1:0] mem_wdata_o
);

  localparam int CmpW  = (CntW > PosW) ? CntW : PosW;
  localparam int WideW = (VALUE_BITS > ValW) ? VALUE_BITS : ValW;
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntMax = CntW'(LIST_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_FIN, S_RD_FRONT, S_RD_BACK, S_CAPT, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    K_INS, K_REM, K_FIND, K_NONE
  } kind_e;

  state_e                  state_q, state_d;
  kind_e                   kind_q, kind_d;
  status_e                 status_q, status_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         rem_q, rem_d;
  logic [CntW-1:0]         fidx_q, fidx_d;
  logic [CntW-1:0]         found_q, found_d;
  logic [AddrW-1:0]        rp_q, rp_d;
  logic [AddrW-1:0]        wa_q, wa_d;
  logic [AddrW-1:0]        ipos_q, ipos_d;
  logic                    up_q, up_d;
  logic                    pend_q, pend_d;
  logic                    hit_q, hit_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  logic [VALUE_BITS-1:0]   front_q, front_d;
  logic [VALUE_BITS-1:0]   back_q, back_d;

  // Decoded request.
  kind_e                   dec_kind;
  status_e                 dec_status;
  logic [CntW-1:0]         dec_pos;
  logic [CmpW-1:0]         pos_ext;
  logic [CmpW-1:0]         cnt_ext;
  logic [CntW-1:0]         cnt_m1;
  logic [CntW-1:0]         pos_p1;
  logic [CntW-1:0]         rem_m1;
  logic [CntW-1:0]         last_idx;
  logic                    full;
  logic [WideW-1:0]        val_wide;
  logic [WideW-1:0]        front_wide;
  logic [WideW-1:0]        back_wide;

  assign pos_ext  = CmpW'(position_i);
  assign cnt_ext  = CmpW'(cnt_q);
  assign full     = (cnt_q == CntMax);
  assign cnt_m1   = cnt_q - CntOne;
  assign pos_p1   = dec_pos + CntOne;
  assign rem_m1   = cnt_m1 - dec_pos;
  assign last_idx = cnt_q - CntOne;
  assign val_wide = WideW'(value_i);

  // Map each request onto an insert, a remove, a search or nothing.
  always_comb begin
    dec_kind   = K_NONE;
    dec_status = ST_OK;
    dec_pos    = '0;
    unique case (req_type_i)
      REQ_PUSH_HEAD, REQ_PUSH_TAIL, REQ_INSERT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_kind = K_INS;
          if (req_type_i == REQ_PUSH_TAIL) begin
            dec_pos = cnt_q;
          end else if (req_type_i == REQ_INSERT) begin
            // A position past the end appends.
            dec_pos = (pos_ext > cnt_ext) ? cnt_q : pos_ext[CntW-1:0];
          end
        end
      end
      REQ_POP_HEAD, REQ_POP_TAIL: begin
        if (cnt_q == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_kind = K_REM;
          dec_pos  = (req_type_i == REQ_POP_TAIL) ? cnt_m1 : '0;
        end
      end
      REQ_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_kind = K_REM;
          dec_pos  = pos_ext[CntW-1:0];
        end
      end
      REQ_FIND: begin
        dec_kind = K_FIND;
      end
      default: begin
        // The unused code leaves the store as it is.
      end
    endcase
  end

  // Sequencer next state and memory port control.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    fidx_d      = fidx_q;
    found_d     = found_q;
    rp_d        = rp_q;
    wa_d        = wa_q;
    ipos_d      = ipos_q;
    up_d        = up_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    val_d       = val_q;
    front_d     = front_q;
    back_d      = back_q;
    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = rp_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wa_q;
    mem_wdata_o = mem_rdata_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = dec_kind;
          status_d = dec_status;
          val_d    = val_wide[VALUE_BITS-1:0];
          ipos_d   = dec_pos[AddrW-1:0];
          pend_d   = 1'b0;
          hit_d    = 1'b0;
          fidx_d   = '0;
          found_d  = '0;
          rem_d    = '0;
          rp_d     = '0;
          wa_d     = '0;
          up_d     = 1'b1;
          unique case (dec_kind)
            K_INS: begin
              // Move entries from the back down to the slot, one step up each.
              rem_d = cnt_q - dec_pos;
              rp_d  = cnt_m1[AddrW-1:0];
              wa_d  = cnt_q[AddrW-1:0];
              up_d  = 1'b0;
            end
            K_REM: begin
              // Move the entries after the slot one step down.
              rem_d = rem_m1;
              rp_d  = pos_p1[AddrW-1:0];
              wa_d  = dec_pos[AddrW-1:0];
            end
            K_FIND: begin
              rem_d   = cnt_q;
              found_d = cnt_q;
            end
            default: begin
            end
          endcase
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        // Issue the next read while the previous read's data is used.
        if (rem_q != '0) begin
          mem_re_o = 1'b1;
          rem_d    = rem_q - CntOne;
          rp_d     = up_q ? rp_q + AddrW'(1) : rp_q - AddrW'(1);
        end
        pend_d = (rem_q != '0);
        if (pend_q) begin
          if (kind_q == K_FIND) begin
            if (!hit_q && (mem_rdata_i == val_q)) begin
              hit_d   = 1'b1;
              found_d = fidx_q;
            end
            fidx_d = fidx_q + CntOne;
          end else begin
            mem_we_o = 1'b1;
            wa_d     = up_q ? wa_q + AddrW'(1) : wa_q - AddrW'(1);
          end
        end
        // The last pending entry is used in the same cycle the walk ends.
        if (rem_q == '0) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (kind_q == K_INS) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ipos_q;
          mem_wdata_o = val_q;
          cnt_d       = cnt_q + CntOne;
        end else if (kind_q == K_REM) begin
          cnt_d = cnt_q - CntOne;
        end
        state_d = S_RD_FRONT;
      end

      S_RD_FRONT: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = '0;
        state_d     = S_RD_BACK;
      end

      S_RD_BACK: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = last_idx[AddrW-1:0];
        front_d     = mem_rdata_i;
        state_d     = S_CAPT;
      end

      S_CAPT: begin
        back_d  = mem_rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= K_NONE;
      status_q <= ST_OK;
      cnt_q    <= '0;
      rem_q    <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      pend_q   <= pend_d;
      hit_q    <= hit_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    fidx_q  <= fidx_d;
    found_q <= found_d;
    rp_q    <= rp_d;
    wa_q    <= wa_d;
    ipos_q  <= ipos_d;
    up_q    <= up_d;
    val_q   <= val_d;
    front_q <= front_d;
    back_q  <= back_d;
  end

  // Result fields; front and back read as zero for an empty store.
  assign front_wide = (cnt_q == '0) ? '0 : WideW'(front_q);
  assign back_wide  = (cnt_q == '0) ? '0 : WideW'(back_q);
  assign front_o    = front_wide[ValW-1:0];
  assign back_o     = back_wide[ValW-1:0];
  assign status_o   = status_q;
  assign found_o    = found_q;
  assign length_o   = cnt_q;

endmodule

`default_nettype wire

// ----- rtl/isq_checker.sv -----
// Port-level checks for the indexed sequence store, bound to the top level.
// Depends on isq_pkg and indexed_sequence_store_core.
`default_nettype none

module isq_checker import isq_pkg::*; #(
  parameter int LIST_DEPTH = 16,
  localparam int CntW = $clog2(LIST_DEPTH + 1)
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            req_valid_i,
  input wire logic            req_ready_i,
  input wire logic            rsp_valid_i,
  input wire logic [1:0]      status_i,
  input wire logic [ValW-1:0] front_i,
  input wire logic [ValW-1:0] back_i,
  input wire logic [CntW-1:0] length_i,
  input wire logic            empty_i
);

  // The store never reports more values than it can hold.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (length_i <= CntW'(LIST_DEPTH)))
    else $error("reported length exceeds the store depth");

  // The empty flag agrees with the length.
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (empty_i == (length_i == '0)))
    else $error("empty flag disagrees with length");

  // An empty store reports zero at both ends.
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && empty_i) |-> ((front_i == '0) && (back_i == '0)))
    else $error("empty store reports a nonzero front or back");

  // An empty status only comes with an empty store.
  a_status_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (status_i == ST_EMPTY)) |-> empty_i)
    else $error("empty status on a store that holds values");

  // One request at a time: ready drops after a request is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("new request taken while one is in progress");

endmodule

bind indexed_sequence_store_core isq_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_isq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .status_i    (rsp_o.status),
  .front_i     (rsp_o.front_value),
  .back_i      (rsp_o.back_value),
  .length_i    (rsp_o.length),
  .empty_i     (rsp_o.is_empty)
);

`default_nettype wire

// ----- test/tb_indexed_sequence_store_core.sv -----
// Testbench for indexed_sequence_store_core: drives requests, predicts each
// response with a behavioral copy of the list and checks every field.
// Depends on isq_pkg, isq_if and the RTL of the store.

module tb_indexed_sequence_store_core;
  import isq_pkg::*;

  localparam int STORE_DEPTH = 16;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int EXP_DEPTH   = 16;

  // The one request code that the package leaves unnamed.
  localparam logic [ReqW-1:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] found;
    logic [ValW-1:0]  front;
    logic [ValW-1:0]  back;
    logic [CNT_W-1:0] len;
    logic             empty;
  } store_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  isq_req_if                   req_if ();
  isq_rsp_if #(.CNT_W(CNT_W)) rsp_if ();

  indexed_sequence_store_core #(
    .LIST_DEPTH(STORE_DEPTH),
    .VALUE_BITS(ValW)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Expected contents of the store, kept in step with accepted requests.
  logic [ValW-1:0] list_vals [STORE_DEPTH];
  int unsigned     list_len;

  // Expected responses in request order, held in a ring.
  store_result_t exp_fifo [EXP_DEPTH];
  int            exp_wr = 0;
  int            exp_rd = 0;
  int            error_count;
  bit            no_idle;
  int            stall_left;

  always #10 clk_i = ~clk_i;

  // Make room at a position and write the value there; refused when full.
  function automatic status_e list_insert(int unsigned pos, logic [ValW-1:0] val);
    int unsigned i;
    if (list_len >= STORE_DEPTH) return ST_FULL;
    if (pos > list_len) pos = list_len;
    for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
    list_vals[pos] = val;
    list_len++;
    return ST_OK;
  endfunction

  // Close the gap at a position; refused when the position is past the end.
  function automatic status_e list_remove(int unsigned pos);
    int unsigned i;
    if (pos >= list_len) return ST_BADPOS;
    for (i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
    return ST_OK;
  endfunction

  // Apply one request to the expected list and build the response it gives.
  function automatic store_result_t predict_result(logic [ReqW-1:0] req,
                                                   logic [ValW-1:0] val,
                                                   logic [PosW-1:0] pos);
    store_result_t r;
    int unsigned   i;
    bit            hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (req)
      REQ_PUSH_HEAD: r.status = list_insert(0, val);
      REQ_PUSH_TAIL: r.status = list_insert(list_len, val);
      REQ_POP_HEAD:  r.status = (list_len == 0) ? ST_EMPTY : list_remove(0);
      REQ_POP_TAIL:  r.status = (list_len == 0) ? ST_EMPTY : list_remove(list_len - 1);
      REQ_INSERT:    r.status = list_insert(pos, val);
      REQ_REMOVE:    r.status = list_remove(pos);
      REQ_FIND: begin
        r.found = list_len[CNT_W-1:0];
        for (i = 0; i < list_len; i++) begin
          if (!hit && list_vals[i] == val) begin
            r.found = i[CNT_W-1:0];
            hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (list_len > 0) begin
      r.front = list_vals[0];
      r.back  = list_vals[list_len-1];
    end
    r.len   = list_len[CNT_W-1:0];
    r.empty = (list_len == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ValW-1:0] got, logic [ValW-1:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    error_count++;
  endtask

  // Send one request, waiting for the handshake, and record its expected response.
  task automatic send_request(logic [ReqW-1:0] req, logic [ValW-1:0] val,
                              logic [PosW-1:0] pos);
    int gap;
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 5);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= req;
    req_if.value_in <= val;
    req_if.position <= pos;
    do @(posedge clk_i); while (!req_if.ready);
    exp_fifo[exp_wr % EXP_DEPTH] = predict_result(req, val, pos);
    exp_wr++;
  endtask

  // Compare one accepted response with the oldest expectation.
  task automatic check_response();
    store_result_t want;
    if (exp_wr == exp_rd) begin
      report_mismatch("unexpected response, length", rsp_if.length, '0);
      return;
    end
    want = exp_fifo[exp_rd % EXP_DEPTH];
    exp_rd++;
    if (rsp_if.status !== want.status)
      report_mismatch("status", rsp_if.status, want.status);
    if (rsp_if.found_position !== want.found)
      report_mismatch("found_position", rsp_if.found_position, want.found);
    if (rsp_if.front_value !== want.front)
      report_mismatch("front_value", rsp_if.front_value, want.front);
    if (rsp_if.back_value !== want.back)
      report_mismatch("back_value", rsp_if.back_value, want.back);
    if (rsp_if.length !== want.len)
      report_mismatch("length", rsp_if.length, want.len);
    if (rsp_if.is_empty !== want.empty)
      report_mismatch("is_empty", rsp_if.is_empty, want.empty);
  endtask

  // Response side: check accepted responses and stall ready in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) check_response();
      if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, 5);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Values favor a small pool and stored entries so that finds hit often.
  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'h10 + $urandom_range(0, 3);
      3, 4:    return (list_len > 0) ? list_vals[$urandom_range(0, list_len - 1)] : $urandom;
      5:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Positions mostly fall within the list or just at its end.
  function automatic logic [PosW-1:0] pick_position();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, list_len);
  endfunction

  // Mode 0 grows the list, mode 1 shrinks it, mode 2 mixes all codes.
  function automatic logic [ReqW-1:0] pick_request(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return REQ_UNUSED;
    case (mode)
      0: begin
        if (roll < 70) begin
          case ($urandom_range(0, 2))
            0:       return REQ_PUSH_HEAD;
            1:       return REQ_PUSH_TAIL;
            default: return REQ_INSERT;
          endcase
        end
        if (roll < 90) return REQ_FIND;
      end
      1: begin
        if (roll < 70) begin
          case ($urandom_range(0, 2))
            0:       return REQ_POP_HEAD;
            1:       return REQ_POP_TAIL;
            default: return REQ_REMOVE;
          endcase
        end
        if (roll < 90) return REQ_FIND;
      end
      default: ;
    endcase
    return ReqW'($urandom_range(0, 6));
  endfunction

  // Requests on an empty store: pops, removes, find and the unused code.
  task automatic test_empty_store();
    send_request(REQ_POP_HEAD, 32'h0, 6'd0);
    send_request(REQ_POP_TAIL, 32'hFFFF_FFFF, 6'd63);
    send_request(REQ_REMOVE, 32'h0, 6'd0);
    send_request(REQ_REMOVE, 32'h0, 6'd63);
    send_request(REQ_FIND, 32'h0, 6'd0);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63);
  endtask

  // Build five entries by every kind of insertion, then search them.
  task automatic test_build_and_find();
    send_request(REQ_PUSH_HEAD, 32'hFFFF_FFFF, 6'd0);
    send_request(REQ_PUSH_TAIL, 32'h0, 6'd0);
    send_request(REQ_INSERT, 32'h1234_5678, 6'd63);
    send_request(REQ_INSERT, 32'hA5A5_5A5A, 6'd0);
    send_request(REQ_INSERT, 32'h0000_0001, 6'd2);
    send_request(REQ_FIND, 32'h1234_5678, 6'd0);
    send_request(REQ_FIND, 32'hA5A5_5A5A, 6'd0);
    send_request(REQ_FIND, 32'h0, 6'd0);
    send_request(REQ_FIND, 32'hDEAD_BEEF, 6'd0);
    send_request(REQ_UNUSED, 32'h0, 6'd0);
  endtask

  // Remove at the front, at the back and past the end, then pop to empty.
  task automatic test_remove_and_pop();
    send_request(REQ_REMOVE, 32'h0, 6'd0);
    send_request(REQ_REMOVE, 32'h0, 6'd3);
    send_request(REQ_REMOVE, 32'h0, 6'd3);
    send_request(REQ_POP_HEAD, 32'h0, 6'd0);
    send_request(REQ_POP_TAIL, 32'h0, 6'd0);
    send_request(REQ_POP_TAIL, 32'h0, 6'd0);
  endtask

  // Fill to capacity, try every insertion and a find on the full store, then drain.
  task automatic test_fill_and_drain();
    logic [ReqW-1:0] req;
    while (list_len < STORE_DEPTH) begin
      case ($urandom_range(0, 2))
        0:       req = REQ_PUSH_HEAD;
        1:       req = REQ_PUSH_TAIL;
        default: req = REQ_INSERT;
      endcase
      send_request(req, $urandom, pick_position());
    end
    send_request(REQ_PUSH_HEAD, $urandom, 6'd0);
    send_request(REQ_PUSH_TAIL, $urandom, 6'd0);
    send_request(REQ_INSERT, $urandom, pick_position());
    send_request(REQ_FIND, list_vals[STORE_DEPTH-1], 6'd0);
    while (list_len > 0) begin
      case ($urandom_range(0, 2))
        0:       req = REQ_POP_HEAD;
        1:       req = REQ_POP_TAIL;
        default: req = REQ_REMOVE;
      endcase
      send_request(req, $urandom, $urandom_range(0, list_len - 1));
    end
  endtask

  // Random requests in runs that grow, shrink or mix; the tail runs without idling.
  task automatic test_random_sequences(int n_items);
    int mode;
    logic [ReqW-1:0] req;
    mode = 2;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) mode = $urandom_range(0, 2);
      if (k == n_items - 100) no_idle = 1'b1;
      req = pick_request(mode);
      send_request(req, pick_value(), pick_position());
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH_HEAD;
    req_if.value_in = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
    error_count     = 0;
    no_idle         = 1'b0;
    stall_left      = 0;
    list_len        = 0;
    for (int i = 0; i < STORE_DEPTH; i++) list_vals[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_build_and_find();
    test_remove_and_pop();
    test_fill_and_drain();
    test_random_sequences(700);

    req_if.valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
